FILE: design/osp_pkg.sv
// ----------------------------------------------------------------------------
// osp_pkg
// Types and constants shared by the output short protection retry unit and
// its port checker.
// ----------------------------------------------------------------------------
package osp_pkg;

    localparam int CHAN_W    = 3;
    localparam int CUR_W     = 12;
    localparam int DELAY_W   = 16;
    localparam int LIMIT_W   = 3;
    localparam int RETRY_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd2;

    // register values after reset
    localparam logic [CUR_W-1:0]   THRESHOLD_RST = 12'd40;
    localparam logic [DELAY_W-1:0] DELAY_RST     = 16'd100;
    localparam logic [LIMIT_W-1:0] LIMIT_RST     = 3'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic              request_on;
        logic [CUR_W-1:0]  current_sample;
    } t_in;

    typedef struct packed {
        logic [CHAN_W-1:0]  out_channel;
        logic               drive_on;
        logic               fault_flag;
        logic               latched_off;
        logic [RETRY_W-1:0] retries_used;
    } t_out;

endpackage

FILE: design/output_short_protect_retry_unit.sv
// ----------------------------------------------------------------------------
// output_short_protect_retry_unit
// Per-channel short-circuit protection with timed (hiccup) retry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in): one transfer is one tick
//   for one channel: channel number, on-request bit, current reading.
//   Output channel (o_out_valid / i_out_ready / o_out): one result transfer
//   per input transfer, in order: drive level, fault flag, latched-off flag
//   and retry count of that channel after the tick.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   always ready; index 0 threshold, 1 retry delay, 2 retry limit, any other
//   index is dropped. Write only while no tick is in flight.
// Timing:
//   Input register, then result register; one tick is accepted every cycle
//   unless both are full under a stall. Channel state is read and written in
//   the same cycle, so ticks for one channel may follow back to back.
// Reset / stall:
//   Reset clears all channel state (no mark, not armed, counts zero), loads
//   the register defaults and empties both stages. When the receiver stalls,
//   the result register holds and the input register keeps one more tick;
//   o_in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module output_short_protect_retry_unit
    import osp_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tick input
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration registers
    logic [CUR_W-1:0]   r_threshold;
    logic [DELAY_W-1:0] r_delay;
    logic [LIMIT_W-1:0] r_limit;

    // per-channel state
    logic               r_mark  [CHANNELS];
    logic               r_armed [CHANNELS];
    logic [DELAY_W-1:0] r_hold  [CHANNELS];
    logic [RETRY_W-1:0] r_rc    [CHANNELS];

    // pipeline
    logic r_s1_valid;
    t_in  r_s1;
    logic r_out_valid;
    t_out r_out;

    logic               out_free;
    logic               s1_move;
    logic               in_range;
    logic [IDX_W-1:0]   s1_idx;
    logic               drive;
    logic               mark_chk;
    logic               n_mark;
    logic               n_armed;
    logic [DELAY_W-1:0] n_hold;
    logic [RETRY_W-1:0] n_rc;
    logic [RETRY_W-1:0] rc_inc;
    logic [RETRY_W-1:0] limit_ext;
    t_out               n_out;

    assign o_cfg_ready = 1'b1;

    // result register frees when empty or taken this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_delay     <= DELAY_RST;
            r_limit     <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[CUR_W-1:0];
                CFG_DELAY:     r_delay     <= i_cfg_data[DELAY_W-1:0];
                CFG_LIMIT:     r_limit     <= i_cfg_data[LIMIT_W-1:0];
                default:       ;
            endcase
        end
    end

    // tick processing
    assign in_range  = {1'b0, r_s1.channel} < (CHAN_W + 1)'(CHANNELS);
    assign s1_idx    = r_s1.channel[IDX_W-1:0];
    assign limit_ext = {1'b0, r_limit};

    always_comb begin
        drive    = 1'b0;
        mark_chk = 1'b0;
        n_mark   = r_mark[s1_idx];
        n_armed  = r_armed[s1_idx];
        n_hold   = r_hold[s1_idx];
        n_rc     = r_rc[s1_idx];
        rc_inc   = r_rc[s1_idx] + RETRY_W'(1);
        n_out    = '0;
        n_out.out_channel = r_s1.channel;

        if (in_range) begin
            // drive decided from the mark as it stands, then the current check
            drive    = r_s1.request_on && !r_mark[s1_idx];
            mark_chk = r_mark[s1_idx] || (drive && (r_s1.current_sample >= r_threshold));
            n_mark   = mark_chk;

            // hiccup retry: arm, count down, then retry or latch off
            if (mark_chk) begin
                if (!r_armed[s1_idx]) begin
                    n_hold  = r_delay;
                    n_armed = 1'b1;
                end else if (r_hold[s1_idx] != '0) begin
                    n_hold = r_hold[s1_idx] - DELAY_W'(1);
                end else if (rc_inc > limit_ext) begin
                    n_rc    = limit_ext + RETRY_W'(1);
                    n_mark  = 1'b1;
                    n_armed = 1'b1;
                end else begin
                    n_rc    = rc_inc;
                    n_mark  = 1'b0;
                    n_armed = 1'b0;
                end
            end

            n_out.drive_on     = drive;
            n_out.fault_flag   = mark_chk;
            n_out.latched_off  = n_rc > limit_ext;
            n_out.retries_used = n_rc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_mark[c]  <= 1'b0;
                r_armed[c] <= 1'b0;
                r_hold[c]  <= '0;
                r_rc[c]    <= '0;
            end
        end else if (s1_move && in_range) begin
            r_mark[s1_idx]  <= n_mark;
            r_armed[s1_idx] <= n_armed;
            r_hold[s1_idx]  <= n_hold;
            r_rc[s1_idx]    <= n_rc;
        end
    end

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1 <= i_in;
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: design/osp_checker.sv
// ----------------------------------------------------------------------------
// osp_checker
// Port-level checks for the output short protection retry unit.
// ----------------------------------------------------------------------------
module osp_checker
    import osp_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // unknown channel gives an all-zero result
    a_unknown_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ({1'b0, o_out.out_channel} >= (CHAN_W + 1)'(CHANNELS))
        |-> !o_out.drive_on && !o_out.fault_flag && !o_out.latched_off
            && (o_out.retries_used == '0))
        else $error("unknown channel result not zero");

    // latched off only after at least one retry
    a_latched_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.latched_off |-> o_out.retries_used != '0)
        else $error("latched off with zero retries");

    // retry count saturates at limit plus one, at most eight
    a_retry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.retries_used <= RETRY_W'(8))
        else $error("retry count out of range");

endmodule

bind output_short_protect_retry_unit osp_checker #(.CHANNELS(CHANNELS)) u_osp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
